FILE: hdl/ctp_pkg.sv
// Shared constants and types for the circle tangent point block.
package ctp_pkg;

   // quotient bits beyond the coordinate width, enough to detect saturation
   localparam int DIV_GUARD_BITS = 2;

   // queue between front and back end
   localparam int QUEUE_ADDR_BITS = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hdl/ctp_front.sv
// Front end: offset, squared length and inside/outside classification.
module ctp_front #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   input  logic [COORD_WIDTH-1:0]                   from_x,
   input  logic [COORD_WIDTH-1:0]                   from_y,
   input  logic [COORD_WIDTH-1:0]                   center_x,
   input  logic [COORD_WIDTH-1:0]                   center_y,
   input  logic [COORD_WIDTH-2:0]                   radius,
   output logic                                     out_valid,
   output logic [1+4*COORD_WIDTH+4+2*COORD_WIDTH+2+3*COORD_WIDTH-2:0] out_record
);
   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int LW = 2 * W + 2;
   localparam int RQ = 2 * W - 2;

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [DW-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, dx3_ff, dy3_ff;
   logic [W-2:0]  r1_ff, r2_ff, r3_ff;
   logic [W-1:0]  cx1_ff, cy1_ff, cx2_ff, cy2_ff, cx3_ff, cy3_ff;
   logic [LW-1:0] dxsq_ff, dysq_ff, len_ff, diff_ff;
   logic [RQ-1:0] rsq_ff;
   logic          ok_ff;

   logic [DW-1:0] dx_in, dy_in, dx_mag, dy_mag;
   logic [LW-1:0] len_in;
   logic [LW-1:0] rsq_ext;

   assign dx_in  = {from_x[W-1], from_x} - {center_x[W-1], center_x};
   assign dy_in  = {from_y[W-1], from_y} - {center_y[W-1], center_y};
   assign dx_mag = dx1_ff[DW-1] ? (~dx1_ff + 1'b1) : dx1_ff;
   assign dy_mag = dy1_ff[DW-1] ? (~dy1_ff + 1'b1) : dy1_ff;
   assign len_in = dxsq_ff + dysq_ff;
   assign rsq_ext = LW'(rsq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff  <= dx_in;
      dy1_ff  <= dy_in;
      r1_ff   <= radius;
      cx1_ff  <= center_x;
      cy1_ff  <= center_y;

      dxsq_ff <= dx_mag * dx_mag;
      dysq_ff <= dy_mag * dy_mag;
      rsq_ff  <= r1_ff * r1_ff;
      dx2_ff  <= dx1_ff;
      dy2_ff  <= dy1_ff;
      r2_ff   <= r1_ff;
      cx2_ff  <= cx1_ff;
      cy2_ff  <= cy1_ff;

      len_ff  <= len_in;
      diff_ff <= len_in - rsq_ext;
      ok_ff   <= len_in > rsq_ext;
      dx3_ff  <= dx2_ff;
      dy3_ff  <= dy2_ff;
      r3_ff   <= r2_ff;
      cx3_ff  <= cx2_ff;
      cy3_ff  <= cy2_ff;
   end

   assign out_valid  = s3_valid_ff;
   assign out_record = {ok_ff, len_ff, diff_ff, dx3_ff, dy3_ff, r3_ff, cx3_ff, cy3_ff};

endmodule

FILE: hdl/ctp_queue.sv
// Small register queue between front and back end.
module ctp_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [DATA_WIDTH-1:0]     push_data,
   input  logic                      pop,
   output logic [DATA_WIDTH-1:0]     pop_data,
   output ctp_pkg::queue_status_type status
);
   import ctp_pkg::*;

   localparam int DEPTH = 2 ** QUEUE_ADDR_BITS;

   logic [DATA_WIDTH-1:0]      mem_ff [0:DEPTH-1];
   logic [QUEUE_ADDR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_ADDR_BITS:0]   count_ff, count_in;
   logic                       do_push, do_pop;

   assign status.full  = count_ff == (QUEUE_ADDR_BITS+1)'(DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/ctp_sqrt.sv
// Pipelined floored square root, one root bit per stage, with side payload.
module ctp_sqrt #(
   parameter int COORD_WIDTH  = 24,
   parameter int PAYLOAD_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [2*COORD_WIDTH+1:0]  radicand,
   input  logic [PAYLOAD_BITS-1:0]   in_payload,
   output logic                      out_valid,
   output logic [COORD_WIDTH:0]      root,
   output logic [PAYLOAD_BITS-1:0]   out_payload
);
   localparam int RW = COORD_WIDTH + 1;
   localparam int LW = 2 * RW;

   logic [RW:0]             rem_ff   [0:RW];
   logic [RW-1:0]           root_ff  [0:RW];
   logic [LW-1:0]           rad_ff   [0:RW];
   logic [PAYLOAD_BITS-1:0] pay_ff   [0:RW];
   logic                    valid_ff [0:RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      rad_ff[0]  <= radicand;
      pay_ff[0]  <= in_payload;
   end

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW+2:0] rem_sh, trial, diff;
      logic          ge;

      // bring down two radicand bits, try (4*root + 1)
      assign rem_sh = {rem_ff[k], rad_ff[k][LW-1 -: 2]};
      assign trial  = {1'b0, root_ff[k], 2'b01};
      assign ge     = rem_sh >= trial;
      assign diff   = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge ? diff[RW:0] : rem_sh[RW:0];
         root_ff[k+1] <= {root_ff[k][RW-2:0], ge};
         rad_ff[k+1]  <= {rad_ff[k][LW-3:0], 2'b00};
         pay_ff[k+1]  <= pay_ff[k];
      end
   end

   assign out_valid   = valid_ff[RW];
   assign root        = root_ff[RW];
   assign out_payload = pay_ff[RW];

endmodule

FILE: hdl/ctp_div.sv
// Pipelined restoring divider with round to nearest, center offset and saturation.
module ctp_div #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                     clock,
   input  logic [3*COORD_WIDTH+2:0] num,
   input  logic [2*COORD_WIDTH+1:0] den,
   input  logic                     neg,
   input  logic [COORD_WIDTH-1:0]   center,
   output logic [COORD_WIDTH-1:0]   coord
);
   import ctp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int NW = 3 * W + 3;
   localparam int LW = 2 * W + 2;
   localparam int QB = W + DIV_GUARD_BITS;
   localparam int HW = NW - QB;
   localparam int VW = QB + 3;
   localparam logic signed [VW-1:0] CMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [VW-1:0] CMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};

   logic [LW-1:0] rem_ff    [0:QB];
   logic [QB-1:0] low_ff    [0:QB];
   logic [QB-1:0] q_ff      [0:QB];
   logic [LW-1:0] den_ff    [0:QB];
   logic          ovf_ff    [0:QB];
   logic          neg_ff    [0:QB];
   logic [W-1:0]  center_ff [0:QB];
   logic [W-1:0]  coord_ff;

   logic [HW-1:0] num_hi;
   assign num_hi = num[NW-1:QB];

   // quotient at or above 2^QB saturates whatever the center
   always_ff @(posedge clock) begin
      rem_ff[0]    <= LW'(num_hi);
      ovf_ff[0]    <= LW'(num_hi) >= den;
      low_ff[0]    <= num[QB-1:0];
      q_ff[0]      <= '0;
      den_ff[0]    <= den;
      neg_ff[0]    <= neg;
      center_ff[0] <= center;
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [LW:0] rem_sh, diff;
      logic        ge;

      assign rem_sh = {rem_ff[k], low_ff[k][QB-1]};
      assign ge     = rem_sh >= {1'b0, den_ff[k]};
      assign diff   = rem_sh - {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         rem_ff[k+1]    <= ge ? diff[LW-1:0] : rem_sh[LW-1:0];
         low_ff[k+1]    <= {low_ff[k][QB-2:0], 1'b0};
         q_ff[k+1]      <= {q_ff[k][QB-2:0], ge};
         den_ff[k+1]    <= den_ff[k];
         ovf_ff[k+1]    <= ovf_ff[k];
         neg_ff[k+1]    <= neg_ff[k];
         center_ff[k+1] <= center_ff[k];
      end
   end

   logic                 round_up;
   logic [QB:0]          q_round;
   logic signed [VW-1:0] c_ext, q_ext, val;

   assign round_up = {rem_ff[QB], 1'b0} >= {1'b0, den_ff[QB]};
   assign q_round  = ovf_ff[QB] ? {1'b1, {QB{1'b0}}}
                                : ({1'b0, q_ff[QB]} + (QB+1)'(round_up));
   assign c_ext    = VW'($signed(center_ff[QB]));
   assign q_ext    = $signed({2'b00, q_round});
   assign val      = neg_ff[QB] ? (c_ext - q_ext) : (c_ext + q_ext);

   always_ff @(posedge clock) begin
      if (val > CMAX) begin
         coord_ff <= CMAX[W-1:0];
      end else if (val < CMIN) begin
         coord_ff <= CMIN[W-1:0];
      end else begin
         coord_ff <= val[W-1:0];
      end
   end

   assign coord = coord_ff;

endmodule

FILE: hdl/ctp_back.sv
// Back end: square root, tangent numerators, four dividers and result register.
module ctp_back #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [1+4*COORD_WIDTH+4+2*COORD_WIDTH+2+3*COORD_WIDTH-2:0] in_record,
   output logic                   out_strobe,
   output logic                   out_valid_res,
   output logic [COORD_WIDTH-1:0] out_first_x,
   output logic [COORD_WIDTH-1:0] out_first_y,
   output logic [COORD_WIDTH-1:0] out_second_x,
   output logic [COORD_WIDTH-1:0] out_second_y
);
   import ctp_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;
   localparam int LW  = 2 * W + 2;
   localparam int RW  = W + 1;
   localparam int AW  = 2 * W + 4;
   localparam int HL  = AW / 2;
   localparam int HH  = AW - HL;
   localparam int NW  = AW + W - 1;
   localparam int PW  = 1 + LW + 2 * DW + (W - 1) + 2 * W;
   localparam int QB  = W + DIV_GUARD_BITS;
   localparam int DLAT = QB + 2;

   // unpack the front record
   logic          rec_ok;
   logic [LW-1:0] rec_len, rec_diff;
   logic [DW-1:0] rec_dx, rec_dy;
   logic [W-2:0]  rec_r;
   logic [W-1:0]  rec_cx, rec_cy;

   assign {rec_ok, rec_len, rec_diff, rec_dx, rec_dy, rec_r, rec_cx, rec_cy} = in_record;

   logic          sq_valid;
   logic [RW-1:0] sq_root;
   logic [PW-1:0] sq_pay;

   ctp_sqrt #(.COORD_WIDTH(W), .PAYLOAD_BITS(PW)) u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (in_valid),
      .radicand    (rec_diff),
      .in_payload  ({rec_ok, rec_len, rec_dx, rec_dy, rec_r, rec_cx, rec_cy}),
      .out_valid   (sq_valid),
      .root        (sq_root),
      .out_payload (sq_pay)
   );

   logic          sq_ok;
   logic [LW-1:0] sq_len;
   logic [DW-1:0] sq_dx, sq_dy;
   logic [W-2:0]  sq_r;
   logic [W-1:0]  sq_cx, sq_cy;

   assign {sq_ok, sq_len, sq_dx, sq_dy, sq_r, sq_cx, sq_cy} = sq_pay;

   // stage 1: the four cross products
   logic signed [W-1:0]  r_s;
   logic signed [RW:0]   root_s;
   logic signed [2*W:0]  rdx_in, rdy_in;
   logic signed [2*W+2:0] tdx_in, tdy_in;

   assign r_s    = $signed({1'b0, sq_r});
   assign root_s = $signed({1'b0, sq_root});
   assign rdx_in = r_s * $signed(sq_dx);
   assign rdy_in = r_s * $signed(sq_dy);
   assign tdx_in = root_s * $signed(sq_dx);
   assign tdy_in = root_s * $signed(sq_dy);

   logic                  p1_valid_ff, p1_ok_ff;
   logic signed [2*W:0]   rdx_ff, rdy_ff;
   logic signed [2*W+2:0] tdx_ff, tdy_ff;
   logic [LW-1:0]         p1_len_ff;
   logic [W-2:0]          p1_r_ff;
   logic [W-1:0]          p1_cx_ff, p1_cy_ff;

   always_ff @(posedge clock) begin
      rdx_ff    <= rdx_in;
      rdy_ff    <= rdy_in;
      tdx_ff    <= tdx_in;
      tdy_ff    <= tdy_in;
      p1_ok_ff  <= sq_ok;
      p1_len_ff <= sq_len;
      p1_r_ff   <= sq_r;
      p1_cx_ff  <= sq_cx;
      p1_cy_ff  <= sq_cy;
   end

   // stage 2: numerators, split into sign and magnitude
   logic signed [AW-1:0] a_in [0:3];

   assign a_in[0] = AW'(rdx_ff) - AW'(tdy_ff);
   assign a_in[1] = AW'(rdy_ff) + AW'(tdx_ff);
   assign a_in[2] = AW'(rdx_ff) + AW'(tdy_ff);
   assign a_in[3] = AW'(rdy_ff) - AW'(tdx_ff);

   logic          p2_valid_ff, p2_ok_ff;
   logic [AW-1:0] mag_ff [0:3];
   logic          neg2_ff [0:3];
   logic [LW-1:0] p2_len_ff;
   logic [W-2:0]  p2_r_ff;
   logic [W-1:0]  p2_cx_ff, p2_cy_ff;

   // stage 3: magnitude times radius in two partial products
   logic                 p3_valid_ff, p3_ok_ff;
   logic [HL+W-2:0]      plo_ff [0:3];
   logic [HH+W-2:0]      phi_ff [0:3];
   logic                 neg3_ff [0:3];
   logic [LW-1:0]        p3_len_ff;
   logic [W-1:0]         p3_cx_ff, p3_cy_ff;

   // stage 4: full product
   logic                 p4_valid_ff, p4_ok_ff;
   logic [NW-1:0]        num_ff [0:3];
   logic                 neg4_ff [0:3];
   logic [LW-1:0]        p4_len_ff;
   logic [W-1:0]         p4_cx_ff, p4_cy_ff;

   logic [W-1:0]         coord [0:3];

   always_ff @(posedge clock) begin
      p2_ok_ff  <= p1_ok_ff;
      p2_len_ff <= p1_len_ff;
      p2_r_ff   <= p1_r_ff;
      p2_cx_ff  <= p1_cx_ff;
      p2_cy_ff  <= p1_cy_ff;
      p3_ok_ff  <= p2_ok_ff;
      p3_len_ff <= p2_len_ff;
      p3_cx_ff  <= p2_cx_ff;
      p3_cy_ff  <= p2_cy_ff;
      p4_ok_ff  <= p3_ok_ff;
      p4_len_ff <= p3_len_ff;
      p4_cx_ff  <= p3_cx_ff;
      p4_cy_ff  <= p3_cy_ff;
   end

   for (genvar j = 0; j < 4; j++) begin : g_lane
      always_ff @(posedge clock) begin
         neg2_ff[j] <= a_in[j][AW-1];
         mag_ff[j]  <= a_in[j][AW-1] ? AW'(-a_in[j]) : AW'(a_in[j]);
         plo_ff[j]  <= mag_ff[j][HL-1:0] * p2_r_ff;
         phi_ff[j]  <= mag_ff[j][AW-1:HL] * p2_r_ff;
         neg3_ff[j] <= neg2_ff[j];
         num_ff[j]  <= NW'(plo_ff[j]) + (NW'(phi_ff[j]) << HL);
         neg4_ff[j] <= neg3_ff[j];
      end

      // even lanes are x, odd lanes are y
      ctp_div #(.COORD_WIDTH(W)) u_div (
         .clock  (clock),
         .num    (num_ff[j]),
         .den    (p4_len_ff),
         .neg    (neg4_ff[j]),
         .center ((j % 2 == 0) ? p4_cx_ff : p4_cy_ff),
         .coord  (coord[j])
      );
   end

   // valid and ok follow the dividers
   logic dvalid_ff [0:DLAT-1];
   logic dok_ff    [0:DLAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         dvalid_ff[0] <= 1'b0;
      end else begin
         p1_valid_ff <= sq_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         dvalid_ff[0] <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dok_ff[0] <= p4_ok_ff;
   end

   for (genvar k = 1; k < DLAT; k++) begin : g_delay
      always_ff @(posedge clock) begin
         if (reset) begin
            dvalid_ff[k] <= 1'b0;
         end else begin
            dvalid_ff[k] <= dvalid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         dok_ff[k] <= dok_ff[k-1];
      end
   end

   logic         strobe_ff, valid_res_ff;
   logic [W-1:0] fx_ff, fy_ff, sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dvalid_ff[DLAT-1];
      end
   end

   always_ff @(posedge clock) begin
      valid_res_ff <= dok_ff[DLAT-1];
      fx_ff <= dok_ff[DLAT-1] ? coord[0] : '0;
      fy_ff <= dok_ff[DLAT-1] ? coord[1] : '0;
      sx_ff <= dok_ff[DLAT-1] ? coord[2] : '0;
      sy_ff <= dok_ff[DLAT-1] ? coord[3] : '0;
   end

   assign out_strobe    = strobe_ff;
   assign out_valid_res = valid_res_ff;
   assign out_first_x   = fx_ff;
   assign out_first_y   = fy_ff;
   assign out_second_x  = sx_ff;
   assign out_second_y  = sy_ff;

endmodule

FILE: hdl/circle_tangent_points.sv
// Top level of the circle tangent point block.
//
// Tangent points from an external point to a circle, signed fixed point.
// Request: drive start high with req_from_x/y, req_center_x/y and req_radius;
// the transfer happens at a rising edge with start high and busy low.
// Result: one per request, in request order, on the rsp_ ports for exactly one
// cycle while rsp_strobe is high. rsp_valid_res is low, and all four
// coordinates zero, when the point lies on or inside the circle.
// Throughput: one request per cycle, sustained while busy is low; items are
// fully pipelined. The result path runs through the one-bit-per-stage square
// root and the one-bit-per-stage dividers.
// The front end (offset, length, classification) feeds the back end through
// a four-entry queue; busy reflects a full queue.
// The receiver cannot stall; results are presented and dropped the next cycle.
// Reset clears every pipeline valid and the queue; in-flight requests are lost.
module circle_tangent_points #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [COORD_WIDTH-1:0] req_from_x,
   input  logic [COORD_WIDTH-1:0] req_from_y,
   input  logic [COORD_WIDTH-1:0] req_center_x,
   input  logic [COORD_WIDTH-1:0] req_center_y,
   input  logic [COORD_WIDTH-2:0] req_radius,
   output logic                   rsp_strobe,
   output logic                   rsp_valid_res,
   output logic [COORD_WIDTH-1:0] rsp_first_x,
   output logic [COORD_WIDTH-1:0] rsp_first_y,
   output logic [COORD_WIDTH-1:0] rsp_second_x,
   output logic [COORD_WIDTH-1:0] rsp_second_y
);
   import ctp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int RB = 1 + 4 * W + 4 + 2 * W + 2 + 3 * W - 1;

   logic             accept;
   logic             fr_valid;
   logic [RB-1:0]    fr_record, q_record;
   queue_status_type q_status;

   assign accept = start && !busy;
   assign busy   = q_status.full;

   ctp_front #(.COORD_WIDTH(W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .from_x     (req_from_x),
      .from_y     (req_from_y),
      .center_x   (req_center_x),
      .center_y   (req_center_y),
      .radius     (req_radius),
      .out_valid  (fr_valid),
      .out_record (fr_record)
   );

   ctp_queue #(.DATA_WIDTH(RB)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data (fr_record),
      .pop       (!q_status.empty),
      .pop_data  (q_record),
      .status    (q_status)
   );

   ctp_back #(.COORD_WIDTH(W)) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (!q_status.empty),
      .in_record     (q_record),
      .out_strobe    (rsp_strobe),
      .out_valid_res (rsp_valid_res),
      .out_first_x   (rsp_first_x),
      .out_first_y   (rsp_first_y),
      .out_second_x  (rsp_second_x),
      .out_second_y  (rsp_second_y)
   );

endmodule
